@@ design/fpa_pkg.sv @@
package fpa_pkg;

   // Number format and derived widths.
   localparam int FRAC_BITS  = 8;
   localparam int DATA_W     = 32;
   localparam int MANT_W     = 24;
   localparam int MSB_W      = $clog2(DATA_W);
   localparam int DVD_W      = DATA_W + FRAC_BITS;
   localparam int DIV_STEPS  = DVD_W;
   localparam int F_MAG_W    = MANT_W + DATA_W - 1;
   // Input register, two front stages, the divider cells and the output register.
   localparam int PIPE_DEPTH = DIV_STEPS + 4;

   typedef enum logic [3:0] {
      KIND_ADD     = 4'd0,
      KIND_SUB     = 4'd1,
      KIND_MUL     = 4'd2,
      KIND_DIV     = 4'd3,
      KIND_CMP     = 4'd4,
      KIND_MIN     = 4'd5,
      KIND_MAX     = 4'd6,
      KIND_INC     = 4'd7,
      KIND_DEC     = 4'd8,
      KIND_INT2FIX = 4'd9,
      KIND_FIX2INT = 4'd10,
      KIND_FLT2FIX = 4'd11,
      KIND_FIX2FLT = 4'd12
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   // One accepted item as registered at the input.
   typedef struct packed {
      logic                     valid;
      kind_type                 kind;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic [DATA_W-1:0]        fb;
   } req_type;

   // Finished fields of an item that travel beside the divider.
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              q_neg;
      logic [DATA_W-1:0] raw;
      logic [DATA_W-1:0] flt;
      logic              gt;
      logic              lt;
      logic              eq;
      status_type        status;
   } side_type;

   // Contents of one divider cell: partial remainder, the dividend bits not yet
   // used with the quotient bits shifted in behind them, and the divisor.
   typedef struct packed {
      side_type          side;
      logic [DATA_W-1:0] rem;
      logic [DVD_W-1:0]  work;
      logic [DATA_W-1:0] dsr;
   } div_type;

endpackage

@@ design/fixed_point_alu_q24_8.sv @@
// Channel   Direction  Handshake                  Payload
// request   in         start && !busy             req_kind, req_operand_a/b, req_float_bits
// response  out        rsp_valid (one cycle)      rsp_raw_result, rsp_float_result,
//                                                 rsp_a_greater/less/equal, rsp_status
//
// Every item passes from acceptance to its response strobe through one input
// register, two front stages, 40 divider cells (one quotient bit each, 32 plus
// the fraction bits) and one output register.
// A new item is accepted in every cycle; busy stays low, and the response
// cannot be held off. Synchronous reset clears every valid bit in the pipe.
module fixed_point_alu_q24_8 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [3:0]                         req_kind,
   input  logic signed [fpa_pkg::DATA_W-1:0]  req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0]  req_operand_b,
   input  logic [fpa_pkg::DATA_W-1:0]         req_float_bits,
   output logic                               rsp_valid,
   output logic signed [fpa_pkg::DATA_W-1:0]  rsp_raw_result,
   output logic [fpa_pkg::DATA_W-1:0]         rsp_float_result,
   output logic                               rsp_a_greater,
   output logic                               rsp_a_less,
   output logic                               rsp_a_equal,
   output logic [1:0]                         rsp_status
);

   fpa_pkg::req_type  req_in;
   fpa_pkg::req_type  req_ff;
   fpa_pkg::div_type  chain [fpa_pkg::DIV_STEPS+1];
   fpa_pkg::side_type out_in;
   fpa_pkg::side_type out_ff;
   fpa_pkg::div_type  last;

   assign busy = 1'b0;

   // Input register.
   always_comb begin
      req_in.valid = start && !busy;
      req_in.kind  = fpa_pkg::kind_type'(req_kind);
      req_in.a     = req_operand_a;
      req_in.b     = req_operand_b;
      req_in.fb    = req_float_bits;
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (reset) begin
         req_ff.valid <= 1'b0;
      end
   end

   fpa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ff),
      .cell_out (chain[0])
   );

   // Row of divider cells, one quotient bit per cell.
   for (genvar g = 0; g < fpa_pkg::DIV_STEPS; g++) begin : g_cell
      fpa_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_cell (chain[g]),
         .next_cell (chain[g+1])
      );
   end

   // Apply the quotient sign and register the response.
   always_comb begin
      last   = chain[fpa_pkg::DIV_STEPS];
      out_in = last.side;
      if (last.side.is_div) begin
         out_in.raw = last.side.q_neg ? (fpa_pkg::DATA_W'(0) - last.work[fpa_pkg::DATA_W-1:0])
                                      : last.work[fpa_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         out_ff.valid <= 1'b0;
      end
   end

   assign rsp_valid        = out_ff.valid;
   assign rsp_raw_result   = out_ff.raw;
   assign rsp_float_result = out_ff.flt;
   assign rsp_a_greater    = out_ff.gt;
   assign rsp_a_less       = out_ff.lt;
   assign rsp_a_equal      = out_ff.eq;
   assign rsp_status       = out_ff.status;

   // Each accepted item comes out after the fixed pipe depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(fpa_pkg::PIPE_DEPTH) rsp_valid)
      else $error("accepted item did not produce a response on time");

   // A divide by zero returns zero fields.
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == fpa_pkg::STATUS_DIV_ZERO)
         |-> (rsp_raw_result == '0 && rsp_float_result == '0))
      else $error("divide by zero response carries a value");

   // At most one compare flag is set.
   a_cmp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_a_greater, rsp_a_less, rsp_a_equal}))
      else $error("more than one compare flag set");

   // A float result never comes with a fixed result.
   a_float_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_float_result != '0) |-> (rsp_raw_result == '0))
      else $error("float response has a nonzero fixed result");

endmodule

@@ design/fpa_div_cell.sv @@
module fpa_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  fpa_pkg::div_type prev_cell,
   output fpa_pkg::div_type next_cell
);

   fpa_pkg::div_type cell_in;
   fpa_pkg::div_type cell_ff;
   logic [fpa_pkg::DATA_W:0] trial;
   logic take;

   // One restoring step: bring down the next dividend bit and try the divisor.
   always_comb begin
      trial = {prev_cell.rem, prev_cell.work[fpa_pkg::DVD_W-1]}
            - {1'b0, prev_cell.dsr};
      take  = !trial[fpa_pkg::DATA_W];
      cell_in      = prev_cell;
      cell_in.rem  = take ? trial[fpa_pkg::DATA_W-1:0]
                          : {prev_cell.rem[fpa_pkg::DATA_W-2:0],
                             prev_cell.work[fpa_pkg::DVD_W-1]};
      cell_in.work = {prev_cell.work[fpa_pkg::DVD_W-2:0], take};
   end

   // Hand the item to the next cell every cycle.
   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) begin
         cell_ff.side.valid <= 1'b0;
      end
   end

   assign next_cell = cell_ff;

endmodule

@@ design/fpa_front.sv @@
module fpa_front (
   input  logic             clock,
   input  logic             reset,
   input  fpa_pkg::req_type req,
   output fpa_pkg::div_type cell_out
);

   localparam int DW = fpa_pkg::DATA_W;
   localparam int FB = fpa_pkg::FRAC_BITS;
   localparam logic signed [9:0] E_BIAS = 10'(FB - 150);
   localparam logic [7:0] EXP_OFS = 8'(127 - FB);
   localparam int RND_BIT = DW - fpa_pkg::MANT_W - 1;

   typedef struct packed {
      logic                          valid;
      fpa_pkg::kind_type             kind;
      logic [DW-1:0]                 simple;
      logic                          gt;
      logic                          lt;
      logic                          eq;
      fpa_pkg::status_type           status;
      logic signed [2*DW-1:0]        prod;
      logic                          f_special;
      logic                          f_nan;
      logic                          f_sign;
      logic                          f_big;
      logic [fpa_pkg::F_MAG_W-1:0]   f_mag;
      logic                          a_sign;
      logic [DW-1:0]                 a_mag;
      logic [fpa_pkg::MSB_W-1:0]     a_msb;
      logic                          is_div;
      logic                          q_neg;
      logic [DW-1:0]                 b_mag;
   } s2_type;

   s2_type s2_in;
   s2_type s2_ff;
   fpa_pkg::div_type s3_in;
   fpa_pkg::div_type s3_ff;

   // First stage: simple operations, compare flags, the product, operand magnitudes, float
   // decode and mantissa alignment, and the leading one of the fixed value.
   always_comb begin
      logic [7:0]                  f_exp;
      logic [fpa_pkg::MANT_W-1:0]  mant;
      logic signed [9:0]           e;
      logic [9:0]                  s;
      logic [4:0]                  sm1;
      logic [fpa_pkg::MANT_W:0]    half_up;

      s2_in        = '0;
      s2_in.valid  = req.valid;
      s2_in.kind   = req.kind;
      s2_in.status = fpa_pkg::STATUS_OK;

      case (req.kind)
         fpa_pkg::KIND_ADD:     s2_in.simple = req.a + req.b;
         fpa_pkg::KIND_SUB:     s2_in.simple = req.a - req.b;
         fpa_pkg::KIND_MIN:     s2_in.simple = (req.a < req.b) ? req.a : req.b;
         fpa_pkg::KIND_MAX:     s2_in.simple = (req.a > req.b) ? req.a : req.b;
         fpa_pkg::KIND_INC:     s2_in.simple = req.a + DW'(1);
         fpa_pkg::KIND_DEC:     s2_in.simple = req.a - DW'(1);
         fpa_pkg::KIND_INT2FIX: s2_in.simple = req.a <<< FB;
         fpa_pkg::KIND_FIX2INT: s2_in.simple = req.a >>> FB;
         default:               s2_in.simple = '0;
      endcase

      if (req.kind == fpa_pkg::KIND_CMP) begin
         s2_in.gt = req.a > req.b;
         s2_in.lt = req.a < req.b;
         s2_in.eq = req.a == req.b;
      end

      s2_in.prod = req.a * req.b;

      // Magnitudes shared by divide and fixed-to-float.
      s2_in.a_sign = req.a[DW-1];
      s2_in.a_mag  = req.a[DW-1] ? (DW'(0) - req.a) : req.a;
      s2_in.b_mag  = req.b[DW-1] ? (DW'(0) - req.b) : req.b;
      s2_in.q_neg  = req.a[DW-1] ^ req.b[DW-1];
      if (req.kind == fpa_pkg::KIND_DIV) begin
         if (req.b == '0) begin
            s2_in.status = fpa_pkg::STATUS_DIV_ZERO;
         end else begin
            s2_in.is_div = 1'b1;
         end
      end

      // Position of the leading one.
      for (int i = 0; i < DW; i++) begin
         if (s2_in.a_mag[i]) begin
            s2_in.a_msb = fpa_pkg::MSB_W'(i);
         end
      end

      // Float decode and alignment to the fixed grid, rounding half away.
      f_exp           = req.fb[30:23];
      s2_in.f_sign    = req.fb[31];
      s2_in.f_special = f_exp == 8'hFF;
      s2_in.f_nan     = s2_in.f_special && (req.fb[22:0] != '0);
      mant            = {f_exp != 8'h00, req.fb[22:0]};
      e   = ((f_exp == 8'h00) ? 10'sd1 : $signed({2'b00, f_exp})) + E_BIAS;
      s   = 10'(-e);
      sm1 = 5'(s - 10'd1);
      half_up = ((fpa_pkg::MANT_W + 1)'(mant >> sm1) + 1'b1) >> 1;
      if (e >= 10'sd0) begin
         if (e >= 10'sd32) begin
            s2_in.f_big = 1'b1;
         end else begin
            s2_in.f_mag = fpa_pkg::F_MAG_W'(mant) << e[4:0];
         end
      end else if (s <= 10'd25) begin
         s2_in.f_mag = fpa_pkg::F_MAG_W'(half_up);
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end
   end

   // Second stage: product scaling, float saturation, float normalize and
   // round, and the divider load.
   always_comb begin
      logic [DW-1:0]               norm;
      logic [fpa_pkg::MANT_W:0]    q;
      logic                        rnd;
      logic [7:0]                  f_exp_out;
      logic [22:0]                 f_frac_out;

      s3_in             = '0;
      s3_in.side.valid  = s2_ff.valid;
      s3_in.side.is_div = s2_ff.is_div;
      s3_in.side.q_neg  = s2_ff.q_neg;
      s3_in.side.gt     = s2_ff.gt;
      s3_in.side.lt     = s2_ff.lt;
      s3_in.side.eq     = s2_ff.eq;
      s3_in.side.status = s2_ff.status;
      s3_in.work        = {s2_ff.a_mag, FB'(0)};
      s3_in.dsr         = s2_ff.b_mag;

      // Fixed to float: normalize, round to nearest even, pack.
      norm = s2_ff.a_mag << (fpa_pkg::MSB_W'(DW - 1) - s2_ff.a_msb);
      rnd  = norm[RND_BIT] && ((norm[RND_BIT-1:0] != '0) || norm[RND_BIT+1]);
      q    = {1'b0, norm[DW-1:RND_BIT+1]} + (fpa_pkg::MANT_W + 1)'(rnd);
      f_exp_out  = 8'(s2_ff.a_msb) + EXP_OFS + 8'(q[fpa_pkg::MANT_W]);
      f_frac_out = q[fpa_pkg::MANT_W] ? q[23:1] : q[22:0];

      case (s2_ff.kind)
         fpa_pkg::KIND_MUL: begin
            s3_in.side.raw = s2_ff.prod[FB+DW-1:FB];
         end
         fpa_pkg::KIND_FLT2FIX: begin
            if (s2_ff.f_special) begin
               s3_in.side.status = fpa_pkg::STATUS_SAT;
               s3_in.side.raw = s2_ff.f_nan ? '0 :
                                s2_ff.f_sign ? {1'b1, (DW-1)'(0)} : {1'b0, {(DW-1){1'b1}}};
            end else if (s2_ff.f_sign) begin
               if (s2_ff.f_big || s2_ff.f_mag > fpa_pkg::F_MAG_W'(64'h8000_0000)) begin
                  s3_in.side.status = fpa_pkg::STATUS_SAT;
                  s3_in.side.raw    = {1'b1, (DW-1)'(0)};
               end else begin
                  s3_in.side.raw = DW'(0) - s2_ff.f_mag[DW-1:0];
               end
            end else begin
               if (s2_ff.f_big || s2_ff.f_mag > fpa_pkg::F_MAG_W'(64'h7FFF_FFFF)) begin
                  s3_in.side.status = fpa_pkg::STATUS_SAT;
                  s3_in.side.raw    = {1'b0, {(DW-1){1'b1}}};
               end else begin
                  s3_in.side.raw = s2_ff.f_mag[DW-1:0];
               end
            end
         end
         fpa_pkg::KIND_FIX2FLT: begin
            if (s2_ff.a_mag != '0) begin
               s3_in.side.flt = {s2_ff.a_sign, f_exp_out, f_frac_out};
            end
         end
         default: begin
            s3_in.side.raw = s2_ff.simple;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s3_ff <= s3_in;
      if (reset) begin
         s3_ff.side.valid <= 1'b0;
      end
   end

   assign cell_out = s3_ff;

endmodule

@@ bench/tb_fixed_point_alu_q24_8.sv @@
module tb_fixed_point_alu_q24_8;

   localparam int LATENCY = fpa_pkg::PIPE_DEPTH;

   // One result item as predicted or observed.
   typedef struct {
      logic [31:0] raw;
      logic [31:0] flt;
      logic        gt;
      logic        lt;
      logic        eq;
      logic [1:0]  st;
   } alu_out_type;

   // One directed row: when has_exp is set the typed-in result is also checked.
   typedef struct {
      logic [3:0]  kind;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] fb;
      bit          has_exp;
      logic [31:0] exp_raw;
      logic [1:0]  exp_st;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_kind = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic [31:0] req_float_bits = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_raw_result;
   logic [31:0] rsp_float_result;
   logic rsp_a_greater, rsp_a_less, rsp_a_equal;
   logic [1:0] rsp_status;

   alu_out_type pending_results[$];
   int errors = 0;

   fixed_point_alu_q24_8 dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Float bits to fixed, rounding half away from zero, with saturation.
   function automatic logic [31:0] flt_to_fix(input logic [31:0] f, output logic [1:0] st);
      logic [7:0]  ex;
      logic [63:0] m, mag;
      int          e;
      st = fpa_pkg::STATUS_OK;
      ex = f[30:23];
      if (ex == 8'hFF) begin
         st = fpa_pkg::STATUS_SAT;
         if (f[22:0] != 0) return 32'd0;
         return f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (ex == 0) begin
         m = {41'd0, f[22:0]};
         e = -149 + fpa_pkg::FRAC_BITS;
      end else begin
         m = {40'd0, 1'b1, f[22:0]};
         e = int'(ex) - 150 + fpa_pkg::FRAC_BITS;
      end
      if (m == 0) return 32'd0;
      if (e >= 0) mag = (e > 40) ? '1 : (m << e);
      else if (-e > 25) mag = 0;
      else mag = (m + (64'd1 << (-e - 1))) >> (-e);
      if (f[31]) begin
         if (mag > 64'h8000_0000) begin
            st = fpa_pkg::STATUS_SAT;
            return 32'h8000_0000;
         end
         return -mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) begin
         st = fpa_pkg::STATUS_SAT;
         return 32'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   // Fixed to float bits, round to nearest even.
   function automatic logic [31:0] fix_to_flt(input logic signed [31:0] a);
      logic [31:0] mag, q, rem, half;
      int          p, s;
      mag = a[31] ? -a : a;
      if (mag == 0) return 32'd0;
      p = 31;
      while (!mag[p]) p--;
      if (p <= 23) q = mag << (23 - p);
      else begin
         s = p - 23;
         rem = mag & ((32'd1 << s) - 1);
         half = 32'd1 << (s - 1);
         q = mag >> s;
         if (rem > half || (rem == half && q[0])) q++;
         if (q == 32'h0100_0000) begin
            q >>= 1;
            p++;
         end
      end
      return {a[31], 8'(p - fpa_pkg::FRAC_BITS + 127), q[22:0]};
   endfunction

   function automatic alu_out_type alu_result(input logic [3:0] kind,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [31:0] fb);
      alu_out_type        r;
      logic signed [63:0] wide;
      r = '{default: '0};
      case (kind)
         fpa_pkg::KIND_ADD: r.raw = a + b;
         fpa_pkg::KIND_SUB: r.raw = a - b;
         fpa_pkg::KIND_MUL: begin
            wide = 64'(a) * 64'(b);
            wide = wide >>> fpa_pkg::FRAC_BITS;
            r.raw = wide[31:0];
         end
         fpa_pkg::KIND_DIV: begin
            if (b == 0) r.st = fpa_pkg::STATUS_DIV_ZERO;
            else begin
               wide = (64'(a) <<< fpa_pkg::FRAC_BITS) / 64'(b);
               r.raw = wide[31:0];
            end
         end
         fpa_pkg::KIND_CMP: begin
            r.gt = a > b;
            r.lt = a < b;
            r.eq = a == b;
         end
         fpa_pkg::KIND_MIN: r.raw = (a < b) ? a : b;
         fpa_pkg::KIND_MAX: r.raw = (a > b) ? a : b;
         fpa_pkg::KIND_INC: r.raw = a + 1;
         fpa_pkg::KIND_DEC: r.raw = a - 1;
         fpa_pkg::KIND_INT2FIX: r.raw = a << fpa_pkg::FRAC_BITS;
         fpa_pkg::KIND_FIX2INT: r.raw = a >>> fpa_pkg::FRAC_BITS;
         fpa_pkg::KIND_FLT2FIX: r.raw = flt_to_fix(fb, r.st);
         fpa_pkg::KIND_FIX2FLT: r.flt = fix_to_flt(a);
         default: ;
      endcase
      return r;
   endfunction

   // Send one item; the predicted result is queued when it is accepted.
   task automatic send_item(input logic [3:0] kind, input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] fb);
      start <= 1'b1;
      req_kind <= kind;
      req_operand_a <= a;
      req_operand_b <= b;
      req_float_bits <= fb;
      do @(posedge clock); while (busy);
      pending_results.push_back(alu_result(kind, a, b, fb));
   endtask

   // Random gap after an item: usually none or short, sometimes long.
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 9);
      if (n < 5) return;
      start <= 1'b0;
      repeat ((n == 9) ? $urandom_range(10, 60) : $urandom_range(1, 3)) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 600) - 300;
         3: return $urandom_range(0, 8) << 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_float();
      logic [31:0] f;
      f = $urandom;
      case ($urandom_range(0, 4))
         0: f[30:23] = 8'(127 + $urandom_range(0, 30) - 10);
         1: f[30:23] = 8'(150 - $urandom_range(0, 30));
         2: f[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: ;
      endcase
      return f;
   endfunction

   // Compare each result with the oldest prediction.
   always @(posedge clock) begin
      alu_out_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_raw_result !== want.raw) begin
               $error("raw_result: expected %h, got %h", want.raw, rsp_raw_result);
               errors++;
            end
            if (rsp_float_result !== want.flt) begin
               $error("float_result: expected %h, got %h", want.flt, rsp_float_result);
               errors++;
            end
            if (rsp_a_greater !== want.gt) begin
               $error("a_greater: expected %b, got %b", want.gt, rsp_a_greater);
               errors++;
            end
            if (rsp_a_less !== want.lt) begin
               $error("a_less: expected %b, got %b", want.lt, rsp_a_less);
               errors++;
            end
            if (rsp_a_equal !== want.eq) begin
               $error("a_equal: expected %b, got %b", want.eq, rsp_a_equal);
               errors++;
            end
            if (rsp_status !== want.st) begin
               $error("status: expected %0d, got %0d", want.st, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("** fixed_point_alu_q24_8: FAILED **");
      $finish;
   end

   initial begin
      row_type     rows[$];
      alu_out_type r;
      int          wait_cycles;

      // Directed rows: extremes, every kind, and the special cases.
      rows = '{
         '{fpa_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h1, 0, 1, 32'h8000_0000, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_SUB, 32'h8000_0000, 32'h1, 0, 1, 32'h7FFF_FFFF, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0},
         '{fpa_pkg::KIND_MUL, 32'hFFFF_FF00, 32'h0000_0180, 0, 0, 0, 0},
         '{fpa_pkg::KIND_DIV, 32'h0000_0100, 32'h0, 0, 1, 32'h0, fpa_pkg::STATUS_DIV_ZERO},
         '{fpa_pkg::KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0},
         '{fpa_pkg::KIND_DIV, 32'hFFFF_FF01, 32'h0000_0300, 0, 0, 0, 0},
         '{fpa_pkg::KIND_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'h0, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_CMP, 32'h5, 32'h5, 0, 0, 0, 0},
         '{fpa_pkg::KIND_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000,
           fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'h7FFF_FFFF,
           fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_INC, 32'h7FFF_FFFF, 0, 0, 1, 32'h8000_0000, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_DEC, 32'h8000_0000, 0, 0, 1, 32'h7FFF_FFFF, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_INT2FIX, 32'h00FF_FFFF, 0, 0, 1, 32'hFFFF_FF00, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_FIX2INT, 32'hFFFF_FF01, 0, 0, 1, 32'hFFFF_FFFF, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_FLT2FIX, 0, 0, 32'h7F80_0000, 1, 32'h7FFF_FFFF, fpa_pkg::STATUS_SAT},
         '{fpa_pkg::KIND_FLT2FIX, 0, 0, 32'hFF80_0000, 1, 32'h8000_0000, fpa_pkg::STATUS_SAT},
         '{fpa_pkg::KIND_FLT2FIX, 0, 0, 32'h7FC0_0001, 1, 32'h0, fpa_pkg::STATUS_SAT},
         '{fpa_pkg::KIND_FLT2FIX, 0, 0, 32'hCB00_0000, 1, 32'h8000_0000, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_FLT2FIX, 0, 0, 32'h3B80_0000, 0, 0, 0},
         '{fpa_pkg::KIND_FLT2FIX, 0, 0, 32'h0000_0001, 1, 32'h0, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_FIX2FLT, 32'h8000_0000, 0, 0, 1, 32'h0, fpa_pkg::STATUS_OK},
         '{fpa_pkg::KIND_FIX2FLT, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
         '{4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, fpa_pkg::STATUS_OK}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Rows with a typed-in result are checked against it before use.
      foreach (rows[i]) begin
         r = alu_result(rows[i].kind, rows[i].a, rows[i].b, rows[i].fb);
         if (rows[i].has_exp && (r.raw !== rows[i].exp_raw || r.st !== rows[i].exp_st)) begin
            $error("row %0d raw_result/status: expected %h/%0d, got %h/%0d", i,
                   rows[i].exp_raw, rows[i].exp_st, r.raw, r.st);
            errors++;
         end
         send_item(rows[i].kind, rows[i].a, rows[i].b, rows[i].fb);
         idle_gap();
      end

      // Random items over all sixteen kind codes.
      repeat (1250) begin
         send_item($urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 12)),
                   rand_operand(), rand_operand(), rand_float());
         idle_gap();
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 20 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("** fixed_point_alu_q24_8: PASSED **");
      else
         $display("** fixed_point_alu_q24_8: FAILED **");
      $finish;
   end

endmodule

@@ fixed_point_alu_q24_8.f @@
design/fpa_pkg.sv
design/fpa_div_cell.sv
design/fpa_front.sv
design/fixed_point_alu_q24_8.sv
bench/tb_fixed_point_alu_q24_8.sv
